[rtl/core/sfr_pkg.sv]
// Shared types, frame constants and CRC-16/MODBUS byte update for the frame receiver.
package sfr_pkg;

    localparam logic [7:0]  HDR0_BYTE   = 8'hFF;
    localparam logic [7:0]  HDR1_BYTE   = 8'hEE;
    localparam logic [7:0]  TRL0_BYTE   = 8'hDD;
    localparam logic [7:0]  TRL1_BYTE   = 8'hCC;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam int          QUEUE_DEPTH = 2;

    // completed frame, handed from front to back
    typedef struct packed {
        logic        ok;
        logic        bank;
        logic [31:0] good;
        logic [31:0] bad;
    } frame_desc_t;

    // back tells front a word bank has been fully read out
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/sfr_front.sv]
// Frame parser: header/trailer match, CRC accumulation, double-banked word store, counters.
module sfr_front #(
    parameter int PAYLOAD_BYTES = 32,
    parameter int CHANNELS      = 14,
    parameter int CH_W          = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    output logic                  push_valid,
    output sfr_pkg::frame_desc_t  push_desc,
    input  logic                  q_full,
    input  sfr_pkg::bank_release_t rel,
    input  logic                  rd_bank,
    input  logic [CH_W-1:0]       rd_ch,
    output logic [15:0]           rd_word,
    output logic [1:0]            bank_busy
);
    import sfr_pkg::*;

    localparam int PH_W = $clog2(PAYLOAD_BYTES + 6);
    localparam logic [PH_W-1:0] PH_HUNT = PH_W'(0);
    localparam logic [PH_W-1:0] PH_HDR1 = PH_W'(1);
    localparam logic [PH_W-1:0] PH_PAY0 = PH_W'(2);
    localparam logic [PH_W-1:0] PH_CRCL = PH_W'(2 + PAYLOAD_BYTES);
    localparam logic [PH_W-1:0] PH_CRCH = PH_W'(3 + PAYLOAD_BYTES);
    localparam logic [PH_W-1:0] PH_TRL0 = PH_W'(4 + PAYLOAD_BYTES);
    localparam logic [PH_W-1:0] PH_TRL1 = PH_W'(5 + PAYLOAD_BYTES);
    localparam logic [PH_W-1:0] PAY_LEN = PH_W'(PAYLOAD_BYTES);
    localparam logic [PH_W-1:0] CH_LEN  = PH_W'(CHANNELS);

    logic [PH_W-1:0] phase_reg, phase_next;
    logic [15:0]     crc_reg, crc_next;
    logic [15:0]     rcrc_reg, rcrc_next;
    logic [31:0]     good_reg, good_next;
    logic [31:0]     bad_reg, bad_next;
    logic            wr_bank_reg, wr_bank_next;
    logic [1:0]      busy_reg, busy_next;

    logic [7:0] lo_reg [2][CHANNELS];
    logic [7:0] hi_reg [2][CHANNELS];

    logic            accept;
    logic [PH_W-1:0] pay_off;
    logic [PH_W-1:0] wsel_full;
    logic [CH_W-1:0] widx;
    logic            in_pay;
    logic            wr_en;
    logic            crc_match;
    logic [PH_W-1:0] rd_pos;
    logic            lo_ok, hi_ok;

    assign accept    = s_tvalid && s_tready;
    assign pay_off   = phase_reg - PH_PAY0;
    assign wsel_full = pay_off >> 1;
    assign widx      = wsel_full[CH_W-1:0];
    assign in_pay    = (phase_reg >= PH_PAY0) && (phase_reg < PH_CRCL);
    assign wr_en     = accept && in_pay && (wsel_full < CH_LEN);
    assign crc_match = (crc_reg == rcrc_reg);

    // hold off first payload byte while target bank still drains; last byte needs a slot
    assign s_tready = !((phase_reg == PH_PAY0) && busy_reg[wr_bank_reg]) &&
                      !((phase_reg == PH_TRL1) && q_full);

    assign push_valid     = accept && (phase_reg == PH_TRL1) && (s_tdata == TRL1_BYTE);
    assign push_desc.ok   = crc_match;
    assign push_desc.bank = wr_bank_reg;
    assign push_desc.good = good_reg + {31'd0, crc_match};
    assign push_desc.bad  = bad_reg + {31'd0, !crc_match};
    assign bank_busy      = busy_reg;

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        rcrc_next    = rcrc_reg;
        good_next    = good_reg;
        bad_next     = bad_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    phase_next = (s_tdata == HDR0_BYTE) ? PH_HDR1 : PH_HUNT;
                end
                PH_HDR1: begin
                    if (s_tdata == HDR1_BYTE) begin
                        phase_next = PH_PAY0;
                        crc_next   = CRC_INIT;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CRCL: begin
                    rcrc_next  = {rcrc_reg[15:8], s_tdata};
                    phase_next = PH_CRCH;
                end
                PH_CRCH: begin
                    rcrc_next  = {s_tdata, rcrc_reg[7:0]};
                    phase_next = PH_TRL0;
                end
                PH_TRL0: begin
                    phase_next = (s_tdata == TRL0_BYTE) ? PH_TRL1 : PH_HUNT;
                end
                PH_TRL1: begin
                    phase_next = PH_HUNT;
                    if (s_tdata == TRL1_BYTE) begin
                        good_next = push_desc.good;
                        bad_next  = push_desc.bad;
                        if (crc_match) begin
                            busy_next[wr_bank_reg] = 1'b1;
                            wr_bank_next           = !wr_bank_reg;
                        end
                    end
                end
                default: begin
                    // payload bytes
                    crc_next   = crc16_byte(crc_reg, s_tdata);
                    phase_next = phase_reg + PH_W'(1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= CRC_INIT;
            rcrc_reg    <= 16'h0000;
            good_reg    <= 32'd0;
            bad_reg     <= 32'd0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= 2'b00;
        end else begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            rcrc_reg    <= rcrc_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (pay_off[0]) begin
                hi_reg[wr_bank_reg][widx] <= s_tdata;
            end else begin
                lo_reg[wr_bank_reg][widx] <= s_tdata;
            end
        end
    end

    // bytes past the payload end read as zero
    assign rd_pos  = PH_W'(rd_ch) << 1;
    assign lo_ok   = rd_pos < PAY_LEN;
    assign hi_ok   = (rd_pos + PH_W'(1)) < PAY_LEN;
    assign rd_word = {hi_ok ? hi_reg[rd_bank][rd_ch] : 8'h00,
                      lo_ok ? lo_reg[rd_bank][rd_ch] : 8'h00};

endmodule

[rtl/core/sfr_queue.sv]
// Short descriptor queue between parser and emitter.
module sfr_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sfr_pkg::frame_desc_t push_data,
    output logic                 full,
    output logic                 head_valid,
    output sfr_pkg::frame_desc_t head_data,
    input  logic                 pop
);
    import sfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    frame_desc_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full       = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/sfr_back.sv]
// Result emitter: walks the channel words of a good frame or sends one error result.
module sfr_back #(
    parameter int CHANNELS = 14,
    parameter int CH_W     = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  sfr_pkg::frame_desc_t   head_data,
    output logic                   pop,
    output logic                   rd_bank,
    output logic [CH_W-1:0]        rd_ch,
    input  logic [15:0]            rd_word,
    output sfr_pkg::bank_release_t rel,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [87:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import sfr_pkg::*;

    logic [CH_W-1:0] ch_reg;
    logic            valid_reg;
    logic [3:0]      chan_reg;
    logic [15:0]     sample_reg;
    logic            ok_reg;
    logic            last_reg;
    logic [31:0]     good_reg;
    logic [31:0]     bad_reg;

    logic load;
    logic last_item;

    assign load      = head_valid && (!valid_reg || m_tready);
    assign last_item = !head_data.ok || (ch_reg == CH_W'(CHANNELS - 1));
    assign pop       = load && last_item;
    assign rd_bank   = head_data.bank;
    assign rd_ch     = ch_reg;
    assign rel.valid = pop && head_data.ok;
    assign rel.bank  = head_data.bank;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'h0, bad_reg, good_reg, sample_reg, chan_reg};
    assign m_tuser  = ok_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ch_reg    <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                ch_reg    <= last_item ? '0 : ch_reg + CH_W'(1);
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            chan_reg   <= head_data.ok ? 4'(ch_reg) : 4'h0;
            sample_reg <= head_data.ok ? rd_word : 16'h0000;
            ok_reg     <= head_data.ok;
            last_reg   <= last_item;
            good_reg   <= head_data.good;
            bad_reg    <= head_data.bad;
        end
    end

endmodule

[rtl/core/sensor_frame_receiver_crc16_unit.sv]
// Top level of the framed serial receiver with CRC-16/MODBUS check.
//
//  channel | dir | tdata fields (lsb up)                              | tuser    | tlast
//  s_      | in  | rx_byte[7:0]                                       | -        | -
//  m_      | out | channel[3:0] sample[15:0] good_frames bad_frames   | frame_ok | last
//
// Input: one byte per cycle. s_tready drops only at the first payload byte when both
// word banks still hold undrained frames, and at the final trailer byte when the
// descriptor queue is full.
// Output: one registered result per cycle while m_tready holds; a good frame gives
// CHANNELS results, a CRC failure one. Synchronous active-low reset; no clearing pass.
module sensor_frame_receiver_crc16_unit #(
    parameter int PAYLOAD_BYTES = 32,
    parameter int CHANNELS      = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // channel[3:0], sample[19:4], good_frames[51:20],
                                   // bad_frames[83:52], zero fill
    output logic        m_tuser,   // frame_ok
    output logic        m_tlast
);
    import sfr_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic            push_valid;
    frame_desc_t     push_desc;
    logic            q_full;
    logic            head_valid;
    frame_desc_t     head_data;
    logic            pop;
    bank_release_t   rel;
    logic            rd_bank;
    logic [CH_W-1:0] rd_ch;
    logic [15:0]     rd_word;
    logic [1:0]      bank_busy;

    // front: byte parsing, CRC, word banks
    sfr_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .CHANNELS     (CHANNELS),
        .CH_W         (CH_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push_valid(push_valid),
        .push_desc (push_desc),
        .q_full    (q_full),
        .rel       (rel),
        .rd_bank   (rd_bank),
        .rd_ch     (rd_ch),
        .rd_word   (rd_word),
        .bank_busy (bank_busy)
    );

    // completed-frame descriptors
    sfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_desc),
        .full      (q_full),
        .head_valid(head_valid),
        .head_data (head_data),
        .pop       (pop)
    );

    // back: result transactions
    sfr_back #(
        .CHANNELS(CHANNELS),
        .CH_W    (CH_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_data (head_data),
        .pop       (pop),
        .rd_bank   (rd_bank),
        .rd_ch     (rd_ch),
        .rd_word   (rd_word),
        .rel       (rel),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // a completed frame never arrives at a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("descriptor queue overflow");

    // a good frame being emitted always reads a bank the front keeps reserved
    a_bank_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_data.ok) |-> bank_busy[head_data.bank])
        else $error("emitting from a released word bank");

    // CRC-error result is a lone, last transaction with zero channel and sample
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[19:0] == 20'd0)))
        else $error("malformed CRC-error result");
`endif

endmodule

[tb/tb_sensor_frame_receiver_crc16_unit.sv]
// Self-checking testbench for the CRC-16/MODBUS framed sensor receiver: random and directed frames.
module tb_sensor_frame_receiver_crc16_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int PAYLOAD_BYTES = 32;
    localparam int CHANNELS      = 14;

    // receive phases, numbered as the block walks through a frame
    localparam int PH_HUNT = 0;
    localparam int PH_HDR1 = 1;
    localparam int PH_PAY0 = 2;
    localparam int PH_CRCL = PH_PAY0 + PAYLOAD_BYTES;
    localparam int PH_CRCH = PH_CRCL + 1;
    localparam int PH_TRL0 = PH_CRCL + 2;

    localparam int REPORT_LIMIT = 10;   // mismatches printed in full
    localparam int SETTLE_CYCLES = 20;  // quiet cycles after the last result
    localparam int HOLD_CYCLES   = 300; // long receiver hold-off under pressure

    // one result transaction, as the block presents it on the m_ side
    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] sample;
        logic        frame_ok;
        logic        last;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } sensor_word_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_TRL0,
        FR_BAD_TRL1,
        FR_BAD_HDR1
    } frame_kind_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_MARKERS
    } fill_t;

    // Tracks the frame state machine byte by byte and holds the channel words still owed.
    class frame_scoreboard_t;
        int           rx_phase;
        logic [15:0]  crc_acc;
        logic [15:0]  crc_rx;
        logic [15:0]  words [CHANNELS];
        logic [31:0]  good_cnt;
        logic [31:0]  bad_cnt;
        sensor_word_t owed_words[$];
        int           errors;

        function new();
            rx_phase        = PH_HUNT;
            crc_acc         = CRC_INIT;
            crc_rx          = '0;
            good_cnt        = '0;
            bad_cnt         = '0;
            errors          = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        // bit-serial reflected CRC, data bit fed in against the low bit of the register
        function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc;
            for (int k = 0; k < 8; k++) begin
                if (c[0] ^ b[k]) begin
                    c = {1'b0, c[15:1]} ^ CRC_POLY;
                end else begin
                    c = {1'b0, c[15:1]};
                end
            end
            return c;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function void note_byte(logic [7:0] b);
            sensor_word_t w;
            int           k;
            if (rx_phase == PH_HUNT) begin
                rx_phase = (b == HDR0_BYTE) ? PH_HDR1 : PH_HUNT;
            end else if (rx_phase == PH_HDR1) begin
                if (b == HDR1_BYTE) begin
                    rx_phase = PH_PAY0;
                    crc_acc  = CRC_INIT;
                    foreach (words[i]) words[i] = '0;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end else if (rx_phase < PH_CRCL) begin
                k       = rx_phase - PH_PAY0;
                crc_acc = crc_update(crc_acc, b);
                // bytes past the last channel word only feed the CRC
                if (k / 2 < CHANNELS) begin
                    if (k % 2 == 1) begin
                        words[k / 2][15:8] = b;
                    end else begin
                        words[k / 2][7:0] = b;
                    end
                end
                rx_phase++;
            end else if (rx_phase == PH_CRCL) begin
                crc_rx[7:0] = b;
                rx_phase    = PH_CRCH;
            end else if (rx_phase == PH_CRCH) begin
                crc_rx[15:8] = b;
                rx_phase     = PH_TRL0;
            end else if (rx_phase == PH_TRL0) begin
                rx_phase = (b == TRL0_BYTE) ? PH_HUNT + 0 + (PH_CRCL + 3) : PH_HUNT;
            end else begin
                rx_phase = PH_HUNT;
                // a bad closing byte drops the frame silently
                if (b == TRL1_BYTE) begin
                    if (crc_acc == crc_rx) begin
                        good_cnt++;
                        for (int i = 0; i < CHANNELS; i++) begin
                            w.channel     = 4'(i);
                            w.sample      = words[i];
                            w.frame_ok    = 1'b1;
                            w.last        = (i == CHANNELS - 1);
                            w.good_frames = good_cnt;
                            w.bad_frames  = bad_cnt;
                            owed_words.push_back(w);
                        end
                    end else begin
                        bad_cnt++;
                        w.channel     = '0;
                        w.sample      = '0;
                        w.frame_ok    = 1'b0;
                        w.last        = 1'b1;
                        w.good_frames = good_cnt;
                        w.bad_frames  = bad_cnt;
                        owed_words.push_back(w);
                    end
                end
            end
        endfunction

        function void check_result(sensor_word_t got);
            sensor_word_t want;
            if (owed_words.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected result: ch=%0d sample=%h ok=%b last=%b good=%0d bad=%0d",
                             $time, got.channel, got.sample, got.frame_ok, got.last,
                             got.good_frames, got.bad_frames);
                end
                return;
            end
            want = owed_words.pop_front();
            if (got.channel !== want.channel || got.sample !== want.sample ||
                got.frame_ok !== want.frame_ok || got.last !== want.last ||
                got.good_frames !== want.good_frames || got.bad_frames !== want.bad_frames) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("[%0t] mismatch: exp ch=%0d sample=%h ok=%b last=%b good=%0d bad=%0d",
                             $time, want.channel, want.sample, want.frame_ok, want.last,
                             want.good_frames, want.bad_frames);
                    $display("[%0t]           got ch=%0d sample=%h ok=%b last=%b good=%0d bad=%0d",
                             $time, got.channel, got.sample, got.frame_ok, got.last,
                             got.good_frames, got.bad_frames);
                end
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------------------------
    // clock, reset and the block
    // ---------------------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // rx_byte[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;           // channel[3:0], sample[19:4], good[51:20], bad[83:52], zeros
    logic        m_tuser;           // frame_ok
    logic        m_tlast;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sensor_frame_receiver_crc16_unit #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .CHANNELS      (CHANNELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    frame_scoreboard_t sb;

    int         gap_pct    = 0;   // chance per cycle that the sender sits idle
    int         stall_pct  = 0;   // chance per cycle that the receiver withholds tready
    int         hold_req   = 0;   // long hold-off requested by the stimulus thread
    logic [7:0] byte_q[$];        // bytes waiting to be offered on the s_ side

    // ---------------------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge. The result is checked before the
    // input is noted; a result can never depend on a byte accepted at the same edge.
    // ---------------------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(sensor_word_t'({m_tdata[3:0], m_tdata[19:4], m_tuser, m_tlast,
                                                m_tdata[51:20], m_tdata[83:52]}));
            end
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Receiver: random back-pressure, or a counted long hold-off when one is requested.
    // ---------------------------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        int hold_left;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------------------------

    // Offers one byte; entered and left at a falling edge. Idle cycles are drawn per cycle
    // so the sender sits out roughly gap_pct of them.
    task automatic send_byte(logic [7:0] b);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < gap_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_queued();
        while (byte_q.size() != 0) send_byte(byte_q.pop_front());
    endtask

    // Sender pauses until every owed result has arrived, then lets the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] payload_byte(fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_MARKERS: begin
                // framing bytes inside the payload must not resync the block
                case ($urandom_range(5))
                    0: return HDR0_BYTE;
                    1: return HDR1_BYTE;
                    2: return TRL0_BYTE;
                    3: return TRL1_BYTE;
                    4: return 8'h00;
                    default: return 8'($urandom_range(255));
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Builds one frame, correct or broken in the way asked for, onto byte_q.
    task automatic queue_frame(frame_kind_t kind, fill_t fill);
        logic [7:0]  pay [PAYLOAD_BYTES];
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            pay[i] = payload_byte(fill);
            crc    = sb.crc_update(crc, pay[i]);
        end
        if (kind == FR_BAD_CRC) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        byte_q.push_back(HDR0_BYTE);
        byte_q.push_back((kind == FR_BAD_HDR1) ? HDR1_BYTE ^ 8'($urandom_range(1, 255))
                                               : HDR1_BYTE);
        foreach (pay[i]) byte_q.push_back(pay[i]);
        byte_q.push_back(crc[7:0]);
        byte_q.push_back(crc[15:8]);
        byte_q.push_back((kind == FR_BAD_TRL0) ? TRL0_BYTE ^ 8'($urandom_range(1, 255))
                                               : TRL0_BYTE);
        byte_q.push_back((kind == FR_BAD_TRL1) ? TRL1_BYTE ^ 8'($urandom_range(1, 255))
                                               : TRL1_BYTE);
    endtask

    // Line noise between frames; biased towards the first header byte.
    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            byte_q.push_back(($urandom_range(2) == 0) ? HDR0_BYTE : 8'($urandom_range(255)));
        end
    endtask

    // ---------------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------------
    initial begin
        sb = new();

        // reset held low from the start, released at a falling edge
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // no idling, but a long receiver hold-off while the sender keeps offering: both
        // word banks fill and s_tready must drop at the third frame's first payload byte
        hold_req = HOLD_CYCLES;
        // FF FF EE: the second FF is used up as a bad second header byte, so EE starts nothing
        byte_q.push_back(HDR0_BYTE);
        byte_q.push_back(HDR0_BYTE);
        byte_q.push_back(HDR1_BYTE);
        queue_frame(FR_GOOD, FILL_MARKERS);     // framing bytes buried in the payload
        queue_frame(FR_GOOD, FILL_ONES);        // every word all ones
        queue_frame(FR_BAD_CRC, FILL_RANDOM);   // single error transaction
        send_queued();
        wait_drained();

        // sender idle: line noise and a broken header, ending back in the hunt
        gap_pct   = 62;
        stall_pct = 0;
        queue_noise();
        byte_q.push_back(HDR0_BYTE);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h00);
        send_queued();
        wait_drained();

        // receiver stalling
        gap_pct   = 0;
        stall_pct = 62;
        queue_frame(FR_GOOD, FILL_RANDOM);
        send_queued();
        wait_drained();

        // both idling
        gap_pct   = 36;
        stall_pct = 36;
        queue_frame(FR_GOOD, FILL_RANDOM);
        send_queued();
        wait_drained();

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
